### rtl/wocr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wocr_pkg: shared types for the write-ordered completion reorder buffer
// Constants, table entry layout, state codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wocr_pkg;

  localparam int unsigned WOCR_ENTRIES = 64;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned IN_TDATA_W   = 40;

  typedef logic [1:0] status_t;
  localparam status_t ST_ORDERED = 2'd0;
  localparam status_t ST_BYPASS  = 2'd1;
  localparam status_t ST_REFUSED = 2'd2;

  typedef struct packed {
    logic            valid;
    logic            ready;
    logic            wr_flag;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    TBL_NONE,
    TBL_REG,
    TBL_READY,
    TBL_RETIRE
  } tbl_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ISCAN,
    S_IDEC,
    S_DCHECK,
    S_DLOAD,
    S_DSCAN,
    S_DDEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    clr_step;
    logic    item_load;
    logic    head_load;
    logic    scan_start;
    tbl_op_t tbl_op;
    logic    fifo_push;
    logic    fifo_pop;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_t emit_status;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic hit;
    logic hit_ready;
    logic hit_wr;
    logic free_found;
    logic kind;
    logic wr;
    logic fifo_full;
    logic fifo_empty;
    logic pend_vld;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/wocr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wocr_ctrl: sequencing state machine
// Steps through the table clear, the lookup of each request, the table and
// FIFO updates and the in-order drain of completed writes.
// ----------------------------------------------------------------------------
module wocr_ctrl import wocr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   refuse;

  assign refuse = (!sts.hit && !sts.free_found) || (sts.wr && sts.fifo_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tbl_op      = TBL_NONE;
    cmd.emit_status = ST_ORDERED;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load  = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_ISCAN;
        end
      end
      S_ISCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_IDEC;
        end
      end
      S_IDEC: begin
        if (!sts.kind) begin
          if (refuse) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_REFUSED;
            state_nxt       = S_FINISH;
          end else begin
            cmd.tbl_op    = TBL_REG;
            cmd.fifo_push = sts.wr;
            cmd.cnt_inc   = !sts.hit;
            state_nxt     = S_IDLE;
          end
        end else if (!sts.hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BYPASS;
          state_nxt       = S_FINISH;
        end else if (!sts.hit_wr) begin
          cmd.tbl_op      = TBL_RETIRE;
          cmd.cnt_dec     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_ORDERED;
          state_nxt       = S_DCHECK;
        end else begin
          cmd.tbl_op = TBL_READY;
          state_nxt  = S_DCHECK;
        end
      end
      S_DCHECK: begin
        if (sts.fifo_empty) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.head_load  = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_DSCAN;
      end
      S_DSCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DDEC;
        end
      end
      S_DDEC: begin
        if (!sts.hit) begin
          cmd.fifo_pop = 1'b1;
          state_nxt    = S_DCHECK;
        end else if (!sts.hit_ready) begin
          state_nxt = S_FINISH;
        end else if (!sts.pend_vld || sts.out_free) begin
          cmd.tbl_op      = TBL_RETIRE;
          cmd.cnt_dec     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_ORDERED;
          cmd.fifo_pop    = 1'b1;
          state_nxt       = S_DCHECK;
        end
      end
      S_FINISH: begin
        if (!sts.pend_vld) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/wocr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wocr_dp: task table, write-order FIFO, counters and result registers
// Holds the task table memory with its sequential lookup, the FIFO of write
// ids, the outstanding count, a holding stage for the newest result and the
// output register.
// ----------------------------------------------------------------------------
module wocr_dp import wocr_pkg::*; #(
  parameter  int unsigned ENTRIES = WOCR_ENTRIES,
  localparam int unsigned IW      = $clog2(ENTRIES),
  localparam int unsigned CW      = $clog2(ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_kind,
  input  logic [ID_W-1:0] in_id,
  input  logic            in_wr,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic            out_ready,
  output logic            out_vld,
  output logic [ID_W-1:0] out_id,
  output logic            out_wr,
  output status_t         out_status,
  output logic [CW-1:0]   out_cnt,
  output logic            out_last
);

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [IW:0]   SCAN_END = (IW + 1)'(ENTRIES);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  entry_t          tbl_mem [ENTRIES];
  logic [ID_W-1:0] fifo_mem [ENTRIES];

  entry_t          tbl_rd_r;
  logic [ID_W-1:0] fifo_rd_r;
  logic            tbl_we;
  logic [IW-1:0]   tbl_waddr;
  entry_t          tbl_wdata;

  logic [IW-1:0]   clr_idx_r;
  logic [IW:0]     scan_cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            chk_vld_r;
  logic [IW-1:0]   chk_idx_r;
  logic            hit_r;
  logic [IW-1:0]   hit_idx_r;
  logic            hit_ready_r;
  logic            hit_wr_r;
  logic            free_r;
  logic [IW-1:0]   free_idx_r;
  logic            chk_hit;
  logic            chk_free;

  logic [ID_W-1:0] key_r;
  logic            kind_r;
  logic            wr_r;

  logic [IW-1:0]   head_r;
  logic [IW-1:0]   tail_r;
  logic [CW-1:0]   fcnt_r;
  logic [CW-1:0]   cnt_r;

  logic            ordered;
  logic            pend_vld_r;
  logic [ID_W-1:0] pend_id_r;
  logic            pend_wr_r;
  status_t         pend_st_r;
  logic [CW-1:0]   pend_cnt_r;
  logic            out_load;
  logic            out_vld_r;
  logic [ID_W-1:0] out_id_r;
  logic            out_wr_r;
  status_t         out_st_r;
  logic [CW-1:0]   out_cnt_r;
  logic            out_last_r;

  assign chk_hit  = busy_r && chk_vld_r && tbl_rd_r.valid && (tbl_rd_r.id == key_r);
  assign chk_free = busy_r && chk_vld_r && !tbl_rd_r.valid && !free_r;
  assign ordered  = (cmd.emit_status == ST_ORDERED);
  assign out_load = (cmd.emit && pend_vld_r) || cmd.flush;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = hit_idx_r;
    tbl_wdata = '0;
    if (cmd.clr_step) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx_r;
    end else begin
      case (cmd.tbl_op)
        TBL_REG: begin
          tbl_we    = 1'b1;
          tbl_waddr = hit_r ? hit_idx_r : free_idx_r;
          tbl_wdata = '{valid: 1'b1, ready: 1'b0, wr_flag: wr_r, id: key_r};
        end
        TBL_READY: begin
          tbl_we    = 1'b1;
          tbl_wdata = '{valid: 1'b1, ready: 1'b1, wr_flag: hit_wr_r, id: key_r};
        end
        TBL_RETIRE: begin
          tbl_we = 1'b1;
        end
        default: begin
          tbl_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[scan_cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.fifo_push) begin
      fifo_mem[tail_r] <= key_r;
    end
    fifo_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      scan_cnt_r <= '0;
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      chk_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      fcnt_r     <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
        busy_r     <= 1'b1;
        done_r     <= 1'b0;
        chk_vld_r  <= 1'b0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else if (busy_r) begin
        if (scan_cnt_r < SCAN_END) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          chk_vld_r  <= 1'b1;
        end else begin
          chk_vld_r <= 1'b0;
        end
        if (chk_hit) begin
          hit_r  <= 1'b1;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (chk_vld_r && (chk_idx_r == LAST_IDX)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        if (chk_free) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.fifo_push) begin
        tail_r <= (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
        fcnt_r <= fcnt_r + 1'b1;
      end else if (cmd.fifo_pop) begin
        head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
        fcnt_r <= fcnt_r - 1'b1;
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.emit) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      chk_idx_r <= scan_cnt_r[IW-1:0];
    end
    if (chk_hit) begin
      hit_idx_r   <= chk_idx_r;
      hit_ready_r <= tbl_rd_r.ready;
      hit_wr_r    <= tbl_rd_r.wr_flag;
    end
    if (chk_free) begin
      free_idx_r <= chk_idx_r;
    end
    if (cmd.item_load) begin
      key_r  <= in_id;
      kind_r <= in_kind;
      wr_r   <= in_wr;
    end else if (cmd.head_load) begin
      key_r <= fifo_rd_r;
    end
    if (out_load) begin
      out_id_r   <= pend_id_r;
      out_wr_r   <= pend_wr_r;
      out_st_r   <= pend_st_r;
      out_cnt_r  <= pend_cnt_r;
      out_last_r <= cmd.flush;
    end
    if (cmd.emit) begin
      pend_id_r  <= key_r;
      pend_wr_r  <= ordered ? hit_wr_r : wr_r;
      pend_st_r  <= cmd.emit_status;
      pend_cnt_r <= cnt_r - CW'(ordered);
    end
  end

  always_comb begin
    sts.clr_last   = (clr_idx_r == LAST_IDX);
    sts.scan_done  = done_r;
    sts.hit        = hit_r;
    sts.hit_ready  = hit_ready_r;
    sts.hit_wr     = hit_wr_r;
    sts.free_found = free_r;
    sts.kind       = kind_r;
    sts.wr         = wr_r;
    sts.fifo_full  = (fcnt_r == FULL_CNT);
    sts.fifo_empty = (fcnt_r == '0);
    sts.pend_vld   = pend_vld_r;
    sts.out_free   = !out_vld_r || out_ready;
  end

  assign out_vld    = out_vld_r;
  assign out_id     = out_id_r;
  assign out_wr     = out_wr_r;
  assign out_status = out_st_r;
  assign out_cnt    = out_cnt_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

### rtl/write_ordered_completion_reorder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// write_ordered_completion_reorder_top: completion reorder buffer
// Registers tasks, takes their completions, and returns reads at once and
// writes strictly in registration order.
// ----------------------------------------------------------------------------
// The input stream carries requests: tuser 0 registers a task, tuser 1
// completes one. Registrations give no result unless the table is full for a new
// id or the write FIFO is full for a write, which gives one refused result. A completion gives one bypass
// result for an unknown id, or the completed read and then every write that
// has become ready at the head of the write order. The result stream's tlast
// marks the final result of a request.
// Each table lookup scans the table memory one entry per cycle; a request
// takes one lookup, plus one more for every write FIFO head examined while
// draining. One request is worked on at a time. After reset the block clears
// every table entry with in_tready low. Results pass through a holding stage
// and an output register; while the receiver stalls, the drain pauses and no
// new request is taken until the pending results of the current one are out.
// ----------------------------------------------------------------------------
module write_ordered_completion_reorder_top import wocr_pkg::*; #(
  parameter  int unsigned ENTRIES = WOCR_ENTRIES,
  localparam int unsigned CW      = $clog2(ENTRIES + 1),
  localparam int unsigned OTW     = ((ID_W + 1 + CW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // task_id, write flag, zero pad
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OTW-1:0]        out_tdata,  // out_task_id, write flag, outstanding, pad
  output logic [1:0]            out_tuser,  // status
  output logic                  out_tlast
);

  cmd_t            cmd;
  sts_t            sts;
  logic [ID_W-1:0] res_id;
  logic            res_wr;
  status_t         res_status;
  logic [CW-1:0]   res_cnt;

  wocr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wocr_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tuser),
    .in_id      (in_tdata[ID_W-1:0]),
    .in_wr      (in_tdata[ID_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_vld    (out_tvalid),
    .out_id     (res_id),
    .out_wr     (res_wr),
    .out_status (res_status),
    .out_cnt    (res_cnt),
    .out_last   (out_tlast)
  );

  assign out_tdata = OTW'({res_cnt, res_wr, res_id});
  assign out_tuser = res_status;

endmodule
`default_nettype wire

### tb/write_ordered_completion_reorder_top_tb.sv
// ----------------------------------------------------------------------------
// write_ordered_completion_reorder_top_tb: self-checking bench for the reorder buffer
// Sends register and complete requests over the input stream and keeps its
// own model of the task table, the write order and the pending count. Each
// result from the block is compared with the oldest predicted result. The
// run has directed cases, a full table, a full write FIFO and random traffic
// under several idle and stall patterns.
// ----------------------------------------------------------------------------
module write_ordered_completion_reorder_top_tb;
  import wocr_pkg::*;

  localparam int unsigned ENTRIES     = WOCR_ENTRIES;
  localparam int unsigned CW          = $clog2(ENTRIES + 1);
  localparam int unsigned OTW         = ((ID_W + 1 + CW + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned TAIL_CYCLES = 2 * ENTRIES + 16;
  localparam logic        KIND_REG    = 1'b0;
  localparam logic        KIND_DONE   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            wr;
    status_t         status;
    logic [CW-1:0]   outstanding;
    logic            last;
  } resp_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;  // task_id, write flag, zero pad
  logic                  in_tuser   = 1'b0;  // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OTW-1:0]        out_tdata;  // out_task_id, write flag, outstanding, pad
  logic [1:0]            out_tuser;  // status
  logic                  out_tlast;

  entry_t          task_tbl [ENTRIES] = '{default: '0};
  logic [ID_W-1:0] wr_order [ENTRIES] = '{default: '0};
  int unsigned     wo_head  = 0;
  int unsigned     wo_count = 0;
  int unsigned     pend_cnt = 0;
  resp_t           exp_resp_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          errors         = 0;
  int unsigned cycles         = 0;

  write_ordered_completion_reorder_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[write_ordered_completion_reorder_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int find_task(input logic [ID_W-1:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (task_tbl[i].valid && task_tbl[i].id == id) return i;
    return -1;
  endfunction

  function automatic void add_resp(input logic [ID_W-1:0] id, input logic wr,
                                   input status_t st);
    resp_t r;
    r = '{id: id, wr: wr, status: st, outstanding: pend_cnt[CW-1:0], last: 1'b0};
    exp_resp_q.insert(exp_resp_q.size(), r);
  endfunction

  function automatic void retire_task(input int idx);
    task_tbl[idx].valid = 1'b0;
    task_tbl[idx].ready = 1'b0;
    if (pend_cnt > 0) pend_cnt--;
  endfunction

  function automatic void predict_req(input logic kind, input logic [ID_W-1:0] id,
                                      input logic wr);
    int              idx;
    int              h;
    int              n0;
    logic            fresh;
    logic [ID_W-1:0] hid;
    idx   = find_task(id);
    fresh = 1'b0;
    n0    = exp_resp_q.size();
    if (kind == KIND_REG) begin
      if (idx < 0) begin
        fresh = 1'b1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!task_tbl[i].valid) idx = i;
      end
      if (idx < 0 || (wr && wo_count >= ENTRIES)) begin
        add_resp(id, wr, ST_REFUSED);
      end else begin
        task_tbl[idx] = '{valid: 1'b1, ready: 1'b0, wr_flag: wr, id: id};
        if (wr) begin
          wr_order[(wo_head + wo_count) % ENTRIES] = id;
          wo_count++;
        end
        if (fresh) pend_cnt++;
      end
    end else if (idx < 0) begin
      add_resp(id, wr, ST_BYPASS);
    end else begin
      task_tbl[idx].ready = 1'b1;
      if (!task_tbl[idx].wr_flag) begin
        retire_task(idx);
        add_resp(id, 1'b0, ST_ORDERED);
      end
      while (wo_count > 0) begin
        hid = wr_order[wo_head];
        h   = find_task(hid);
        if (h >= 0) begin
          if (!task_tbl[h].ready) break;
          retire_task(h);
          add_resp(hid, task_tbl[h].wr_flag, ST_ORDERED);
        end
        wo_head = (wo_head + 1) % ENTRIES;
        wo_count--;
      end
    end
    if (exp_resp_q.size() > n0) exp_resp_q[exp_resp_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_resp_q.size() == 0) begin
        $error("unexpected result: out_task_id %h", out_tdata[ID_W-1:0]);
        errors++;
      end else begin
        want = exp_resp_q.pop_front();
        if (out_tdata[ID_W-1:0] !== want.id) begin
          $error("out_task_id: expected %h, actual %h", want.id, out_tdata[ID_W-1:0]);
          errors++;
        end
        if (out_tdata[ID_W] !== want.wr) begin
          $error("out_is_write: expected %0d, actual %0d", want.wr, out_tdata[ID_W]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[ID_W+CW:ID_W+1] !== want.outstanding) begin
          $error("outstanding: expected %0d, actual %0d", want.outstanding,
                 out_tdata[ID_W+CW:ID_W+1]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic send_req(input logic kind, input logic [ID_W-1:0] id, input logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - ID_W - 1){1'b0}}, wr, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_req(kind, id, wr);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_resp_q.size() != 0);
  endtask

  task automatic test_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(KIND_REG, '0, 1'b0);
    send_req(KIND_DONE, '0, 1'b1);
    send_req(KIND_REG, '1, 1'b1);
    send_req(KIND_DONE, '1, 1'b0);
    send_req(KIND_DONE, $urandom(), 1'b1);
    send_req(KIND_DONE, $urandom(), 1'b0);
  endtask

  task automatic test_write_order();
    logic [ID_W-1:0] a;
    a = $urandom();
    send_req(KIND_REG, a, 1'b1);
    send_req(KIND_REG, a + 1, 1'b1);
    send_req(KIND_REG, a + 2, 1'b0);
    send_req(KIND_REG, a + 3, 1'b1);
    send_req(KIND_DONE, a + 3, 1'b0);
    send_req(KIND_DONE, a + 2, 1'b1);
    send_req(KIND_DONE, a + 1, 1'b0);
    send_req(KIND_DONE, a + 1, 1'b1);
    send_req(KIND_DONE, a, 1'b0);
  endtask

  task automatic test_reregister();
    logic [ID_W-1:0] x;
    x = $urandom();
    send_req(KIND_REG, x, 1'b1);
    send_req(KIND_REG, x, 1'b1);
    send_req(KIND_DONE, x, 1'b0);
    send_req(KIND_REG, ~x, 1'b1);
    send_req(KIND_REG, ~x, 1'b0);
    send_req(KIND_REG, x ^ 32'h0001_0000, 1'b1);
    send_req(KIND_DONE, x ^ 32'h0001_0000, 1'b0);
    send_req(KIND_DONE, ~x, 1'b1);
    wait_drained();
  endtask

  task automatic test_table_full();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] live [$];
    logic [ID_W-1:0] t;
    int unsigned     fill;
    int              j;
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    base = $urandom();
    fill = 0;
    while (pend_cnt < ENTRIES) begin
      send_req(KIND_REG, base ^ fill, (wo_count < ENTRIES - 4) && ($urandom_range(1) == 1));
      fill++;
    end
    send_req(KIND_REG, base ^ fill, 1'b0);
    send_req(KIND_REG, base ^ (fill + 1), 1'b1);
    send_req(KIND_REG, task_tbl[0].id, 1'b0);
    foreach (task_tbl[i]) if (task_tbl[i].valid) live.insert(live.size(), task_tbl[i].id);
    for (int i = live.size() - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      t       = live[i];
      live[i] = live[j];
      live[j] = t;
    end
    foreach (live[i]) send_req(KIND_DONE, live[i], $urandom_range(1) == 1);
    wait_drained();
  endtask

  task automatic test_write_fifo_full();
    logic [ID_W-1:0] x;
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    x = $urandom();
    while (wo_count < ENTRIES) send_req(KIND_REG, x, 1'b1);
    send_req(KIND_REG, x, 1'b1);
    send_req(KIND_REG, ~x, 1'b1);
    send_req(KIND_REG, x ^ 32'h0000_8001, 1'b0);
    send_req(KIND_DONE, x ^ 32'h0000_8001, 1'b1);
    send_req(KIND_DONE, x, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int unsigned idle_pct, input int unsigned stall_pct,
                                 input int unsigned n_items);
    logic [ID_W-1:0] pool [8];
    logic [ID_W-1:0] live [$];
    logic [ID_W-1:0] id;
    logic            kind;
    logic            wr;
    int unsigned     r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (pool[i]) pool[i] = $urandom();
    for (int k = 0; k < n_items; k++) begin
      live.delete();
      foreach (task_tbl[i]) if (task_tbl[i].valid) live.insert(live.size(), task_tbl[i].id);
      r  = (pend_cnt >= 16) ? 45 + $urandom_range(42) : $urandom_range(99);
      wr = ($urandom_range(9) < 7);
      if (r < 45) begin
        kind = KIND_REG;
        id   = pool[$urandom_range(7)];
      end else if (r < 88 && live.size() > 0) begin
        kind = KIND_DONE;
        id   = live[$urandom_range(live.size() - 1)];
      end else if (r < 94) begin
        kind = KIND_DONE;
        id   = $urandom();
      end else begin
        kind = KIND_REG;
        id   = $urandom();
      end
      send_req(kind, id, wr);
      if (k == n_items / 2 || $urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_write_order();
    test_reregister();
    test_table_full();
    test_write_fifo_full();
    test_random_mix(0, 0, 60);
    test_random_mix(85, 0, 60);
    test_random_mix(0, 85, 60);
    test_random_mix(38, 38, 60);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && exp_resp_q.size() == 0) begin
      $display("[write_ordered_completion_reorder_top] OK");
    end else begin
      $display("[write_ordered_completion_reorder_top] ERROR");
    end
    $finish;
  end

endmodule
